// ----- design/asal_pkg.sv -----
package asal_pkg;

  typedef enum logic [1:0] {
    CMD_SWITCH  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MAP     = 2'd2
  } cmd_t;

  localparam int HASH_SHIFT = 12;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  process;
    logic        flush_first;
    logic [31:0] virt;
    logic [31:0] phys;
  } req_t;

  typedef struct packed {
    logic [5:0]  asid;
    logic        allocated;
    logic [31:0] tagged_virt;
    logic [31:0] phys_out;
    logic        purged;
    logic [5:0]  purged_asid;
  } rsp_t;

endpackage

// ----- design/asal_stream_if.sv -----
interface asal_stream_if #(parameter type T = logic [0:0]);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- design/asal_ram.sv -----
module asal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/asid_allocator_soft_tlb.sv -----
// ASID allocator with a hashed, direct-mapped software TLB for one processor.
// Each input transaction (switch, release, map) produces exactly one result
// transaction. After reset a clearing pass over max(STLB_ENTRIES, NUM_PROCS)
// entries zeroes the TLB and the process table; no transaction is accepted
// meanwhile. A transaction that needs no allocation passes from accept to
// result through the process-table read, evaluate and output load; a map adds
// a TLB write before the output load.
// An allocation adds a round-robin search of one ASID per cycle, then an
// owner/process-table read-modify-write (owner read, process-table read, an
// owner check when the chosen ASID still has a valid owner, then the write).
// A purge adds a liveness check of each nonzero ASID (owner and process-table
// reads, then a check if it has a valid owner) and a sweep of every TLB entry.
// The input is taken again as soon as the result sits in the output register.
module asid_allocator_soft_tlb #(
  parameter int NUM_ASIDS    = 64,
  parameter int STLB_ENTRIES = 1024,
  parameter int NUM_PROCS    = 64,
  parameter int ASID_SHIFT   = 6
) (
  input logic clk,
  input logic rst,
  asal_stream_if.sink   in_ch,
  asal_stream_if.source out_ch
);
  import asal_pkg::*;

  localparam int AW    = $clog2(NUM_ASIDS);
  localparam int SW    = $clog2(STLB_ENTRIES);
  localparam int PAW   = $clog2(NUM_PROCS);
  localparam int CLR_N = (STLB_ENTRIES > NUM_PROCS) ? STLB_ENTRIES : NUM_PROCS;
  localparam int CW    = $clog2(CLR_N);

  typedef enum logic [16:0] {
    S_CLR     = 17'h00001,
    S_IDLE    = 17'h00002,
    S_RD      = 17'h00004,
    S_EVAL    = 17'h00008,
    S_SRCH    = 17'h00010,
    S_ADJ     = 17'h00020,
    S_PD_OWN  = 17'h00040,
    S_PD_PA   = 17'h00080,
    S_PD_CHK  = 17'h00100,
    S_PS_RD   = 17'h00200,
    S_PS_CHK  = 17'h00400,
    S_OWN_RD  = 17'h00800,
    S_OWN_PA  = 17'h01000,
    S_OWN_CHK = 17'h02000,
    S_FIN     = 17'h04000,
    S_MAP     = 17'h08000,
    S_OUT     = 17'h10000
  } state_t;

  state_t st;

  // transaction registers
  cmd_t            cmd_r;
  logic [PAW-1:0]  proc_r;
  logic            flush_r;
  logic [31:0]     virt_r;
  logic [31:0]     phys_r;
  logic [AW-1:0]   idx;       // search position, then chosen ASID / victim
  logic [AW-1:0]   kcnt;
  logic [AW-1:0]   jcnt;
  logic [SW-1:0]   mcnt;
  logic [CW-1:0]   clr;
  logic [PAW-1:0]  oproc;
  logic [AW-1:0]   last_asid;
  logic [NUM_ASIDS-1:0] owner_vld;
  logic [NUM_ASIDS-1:0] present;
  logic [NUM_ASIDS-1:0] dead;
  logic            alloc_r;
  logic            purged_r;
  logic [AW-1:0]   res_asid;
  logic [31:0]     res_tv;
  logic [31:0]     res_pv;
  logic            out_valid;
  rsp_t            out_data;

  // memory ports
  logic           o_we, p_we, v_we;
  logic [AW-1:0]  o_waddr, o_raddr;
  logic [PAW-1:0] o_wdata, o_rdata;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [AW-1:0]  p_wdata, p_rdata;
  logic [SW-1:0]  v_waddr, v_raddr;
  logic [31:0]    v_wdata, v_rdata;

  // process number folded into the table range
  function automatic logic [PAW-1:0] fold_proc(input logic [5:0] p);
    logic [PAW-1:0] r;
    r = '0;
    for (int v = 0; v < 64; v++) begin
      if (p == 6'(v)) r = PAW'(v % NUM_PROCS);
    end
    return r;
  endfunction

  // next ASID round-robin, skipping zero
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(NUM_ASIDS - 1)) ? AW'(1) : a + AW'(1);
  endfunction

  function automatic logic [5:0] to6(input logic [AW-1:0] a);
    logic [8:0] e;
    e = 9'(a);
    return e[5:0];
  endfunction

  logic [AW-1:0] srch_nxt, adj_vic, sweep_asid;
  logic [63:0]   asid_sh;
  logic [31:0]   tv, hv;
  logic          last_j;

  assign srch_nxt   = wrap_inc(idx);
  assign adj_vic    = (idx == last_asid) ? wrap_inc(idx) : idx;
  assign sweep_asid = v_rdata[ASID_SHIFT +: AW];
  assign asid_sh    = 64'(idx) << ASID_SHIFT;
  assign tv         = virt_r | asid_sh[31:0];
  assign hv         = (tv << 1) ^ (tv >> HASH_SHIFT);
  assign last_j     = (jcnt == AW'(NUM_ASIDS - 1));

  asal_ram #(.WIDTH(PAW), .DEPTH(NUM_ASIDS)) u_owner_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  asal_ram #(.WIDTH(AW), .DEPTH(NUM_PROCS)) u_pasid_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  asal_ram #(.WIDTH(32), .DEPTH(STLB_ENTRIES)) u_virt_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  assign in_ch.ready  = (st == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_comb begin
    o_we    = 1'b0;
    o_waddr = idx;
    o_wdata = proc_r;
    o_raddr = idx;
    p_we    = 1'b0;
    p_waddr = proc_r;
    p_wdata = '0;
    p_raddr = proc_r;
    v_we    = 1'b0;
    v_waddr = hv[SW-1:0];
    v_wdata = '0;
    v_raddr = mcnt;
    case (st)
      S_CLR: begin
        v_we    = ({1'b0, clr} < (CW+1)'(STLB_ENTRIES));
        v_waddr = clr[SW-1:0];
        p_we    = ({1'b0, clr} < (CW+1)'(NUM_PROCS));
        p_waddr = clr[PAW-1:0];
      end
      S_EVAL: begin
        p_we = (cmd_r == CMD_RELEASE) || (cmd_r == CMD_SWITCH && flush_r);
      end
      S_PD_OWN:  o_raddr = jcnt;
      S_PD_PA:   p_raddr = o_rdata;
      S_PS_CHK: begin
        v_we    = dead[sweep_asid];
        v_waddr = mcnt;
      end
      S_OWN_PA:  p_raddr = o_rdata;
      S_OWN_CHK: begin
        p_we    = (p_rdata == idx);
        p_waddr = oproc;
      end
      S_FIN: begin
        o_we    = 1'b1;
        p_we    = 1'b1;
        p_wdata = idx;
      end
      S_MAP: begin
        v_we    = 1'b1;
        v_wdata = (phys_r == 32'd0) ? 32'd0 : tv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      clr       <= '0;
      last_asid <= '0;
      owner_vld <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && out_ch.ready && st != S_OUT) out_valid <= 1'b0;
      case (st)
        S_CLR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(CLR_N - 1)) st <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r    <= cmd_t'(in_ch.data.command);
            proc_r   <= fold_proc(in_ch.data.process);
            flush_r  <= in_ch.data.flush_first;
            virt_r   <= in_ch.data.virt;
            phys_r   <= in_ch.data.phys;
            alloc_r  <= 1'b0;
            purged_r <= 1'b0;
            res_tv   <= '0;
            res_pv   <= '0;
            st       <= S_RD;
          end
        end
        S_RD: st <= S_EVAL;
        S_EVAL: begin
          case (cmd_r)
            CMD_SWITCH: begin
              if (flush_r || p_rdata == '0) begin
                idx  <= last_asid;
                kcnt <= '0;
                st   <= S_SRCH;
              end else begin
                res_asid <= p_rdata;
                st       <= S_OUT;
              end
            end
            CMD_RELEASE: begin
              res_asid <= '0;
              st       <= S_OUT;
            end
            CMD_MAP: begin
              if (p_rdata == '0) begin
                idx  <= last_asid;
                kcnt <= '0;
                st   <= S_SRCH;
              end else begin
                idx <= p_rdata;
                st  <= S_MAP;
              end
            end
            default: begin
              res_asid <= p_rdata;
              st       <= S_OUT;
            end
          endcase
        end
        S_SRCH: begin
          idx  <= srch_nxt;
          kcnt <= kcnt + AW'(1);
          if (!present[srch_nxt] || kcnt == AW'(NUM_ASIDS - 2)) st <= S_ADJ;
        end
        S_ADJ: begin
          idx <= adj_vic;
          if (present[adj_vic]) begin
            // victim is dead regardless of its owner
            dead     <= {{(NUM_ASIDS-1){1'b0}}, 1'b1} << adj_vic;
            jcnt     <= AW'(1);
            purged_r <= 1'b1;
            st       <= S_PD_OWN;
          end else begin
            st <= S_OWN_RD;
          end
        end
        S_PD_OWN: st <= S_PD_PA;
        S_PD_PA: begin
          if (!owner_vld[jcnt]) begin
            dead[jcnt] <= 1'b1;
            if (last_j) begin
              present <= '0;
              mcnt    <= '0;
              st      <= S_PS_RD;
            end else begin
              jcnt <= jcnt + AW'(1);
              st   <= S_PD_OWN;
            end
          end else begin
            st <= S_PD_CHK;
          end
        end
        S_PD_CHK: begin
          if (p_rdata != jcnt) begin
            dead[jcnt]      <= 1'b1;
            owner_vld[jcnt] <= 1'b0;
          end
          if (last_j) begin
            present <= '0;
            mcnt    <= '0;
            st      <= S_PS_RD;
          end else begin
            jcnt <= jcnt + AW'(1);
            st   <= S_PD_OWN;
          end
        end
        S_PS_RD: st <= S_PS_CHK;
        S_PS_CHK: begin
          if (!dead[sweep_asid]) present[sweep_asid] <= 1'b1;
          mcnt <= mcnt + SW'(1);
          st   <= (mcnt == SW'(STLB_ENTRIES - 1)) ? S_OWN_RD : S_PS_RD;
        end
        S_OWN_RD: st <= S_OWN_PA;
        S_OWN_PA: begin
          oproc <= o_rdata;
          st    <= owner_vld[idx] ? S_OWN_CHK : S_FIN;
        end
        S_OWN_CHK: st <= S_FIN;
        S_FIN: begin
          owner_vld[idx] <= 1'b1;
          last_asid      <= idx;
          alloc_r        <= 1'b1;
          res_asid       <= idx;
          st             <= (cmd_r == CMD_MAP) ? S_MAP : S_OUT;
        end
        S_MAP: begin
          present[idx] <= 1'b1;
          res_asid     <= idx;
          res_tv       <= tv;
          res_pv       <= phys_r;
          st           <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid            <= 1'b1;
            out_data.asid        <= to6(res_asid);
            out_data.allocated   <= alloc_r;
            out_data.tagged_virt <= res_tv;
            out_data.phys_out    <= res_pv;
            out_data.purged      <= purged_r;
            out_data.purged_asid <= purged_r ? to6(idx) : 6'd0;
            st                   <= S_IDLE;
          end
        end
        default: st <= S_CLR;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a purge only happens as part of an allocation
  a_purge_alloc: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!out_ch.data.purged || out_ch.data.allocated))
    else $error("purge reported without allocation");

  // allocation never hands out ASID zero
  a_fin_nonzero: assert property (@(posedge clk) disable iff (rst)
    (st == S_FIN) |-> (idx != '0))
    else $error("ASID zero allocated");

  // nothing is accepted during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (rst)
    (st == S_CLR) |=> !(in_ch.valid && in_ch.ready && $past(st) == S_CLR && st == S_CLR))
    else $error("transaction accepted during clearing pass");
`endif

endmodule
